// ----- sv/block_index_table_defines.svh -----
// Assertion macros for the block index table.
// Each takes a label, an antecedent and a consequent; clk and rst come from the
// module that uses them.
`ifndef BLOCK_INDEX_TABLE_DEFINES_SVH
`define BLOCK_INDEX_TABLE_DEFINES_SVH

// Consequent holds in the same cycle
`define BIDX_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("block index table assertion failed");

// Consequent holds in the following cycle
`define BIDX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block index table assertion failed");

`endif

// ----- sv/bidx_pkg.sv -----
`timescale 1ns / 1ps
package bidx_pkg;

  // Table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths
  localparam int KEY_W = 17;
  localparam int BLK_W = 16;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DEL    = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [BLK_W-1:0] block_num;
  } op_t;

  typedef struct packed {
    logic [BLK_W-1:0] match_block;
    logic             found;
    logic [BLK_W-1:0] top_block;
    logic             status;
  } res_t;

  // One stored table row
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [BLK_W-1:0] blk;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_APPEND = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

endpackage

// ----- sv/bidx_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one read port, registered read.
module bidx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/block_index_table.sv -----
`timescale 1ns / 1ps
// Channel  | Signals                       | Beat taken when
// ---------+-------------------------------+---------------------------
// op       | op_valid, op_stall, op_data   | op_valid && !op_stall
// res      | res_valid, res_stall, res_data| res_valid && !res_stall
//
// One op at a time; the sequencer runs S_SCAN, S_APPEND and S_DONE, then res_valid
// rises and the next op can be taken back in S_IDLE.
// S_SCAN makes one pass over the table RAM, one entry read per cycle.
// Reset (rst, synchronous) empties the table; RAM contents are not cleared.
// op_stall is high while an op is in work; a stalled result waits in the
// output register while the next op is already taken.
module block_index_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           op_valid,
  output logic           op_stall,
  input  bidx_pkg::op_t  op_data,
  output logic           res_valid,
  input  logic           res_stall,
  output bidx_pkg::res_t res_data
);
  import bidx_pkg::*;

  state_t           state;
  op_t              cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] count_after;
  logic [IDX_W-1:0] rd_at;
  logic             rd_pend;
  logic             removed;
  logic             found;
  logic [KEY_W-1:0] best_key;
  logic [BLK_W-1:0] match_blk;
  logic [KEY_W-1:0] top_key;
  logic [BLK_W-1:0] top_blk;
  res_t             result;

  logic             issue;
  logic             hit;
  logic             keep;
  logic             room;
  logic             append;
  logic             top_upd;
  logic             srch_upd;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // Table storage
  bidx_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign op_stall = (state != S_IDLE);

  // Scan control: one read per cycle, registered read data
  assign issue   = (state == S_SCAN) && (rd_idx < count);
  assign rd_en   = issue;
  assign rd_addr = rd_idx[IDX_W-1:0];

  // First row with the op's block number is dropped on an add or a delete; later rows move down one.
  // The write lands two rows below the read in flight, so no forwarding needed.
  assign hit  = rd_pend && !removed && (rd_data.blk == cur.block_num)
             && ((cur.cmd == CMD_ADD) || (cur.cmd == CMD_DEL));
  assign keep = rd_pend && !hit;

  assign count_after = count - CNT_W'(removed);
  assign room        = count_after < CNT_W'(ENTRIES);
  assign append      = (state == S_APPEND) && (cur.cmd == CMD_ADD) && room;

  // Highest key above zero, earliest wins; smallest key at or above the ask
  assign top_upd  = keep && (rd_data.key > top_key);
  assign srch_upd = keep && (cur.cmd == CMD_SEARCH) && (rd_data.key >= cur.key)
                 && (!found || (rd_data.key < best_key));

  // Write port: compaction during scan, new row at the end on append
  always_comb begin
    wr_en   = append || (keep && removed);
    wr_addr = rd_at - 1'b1;
    wr_data = rd_data;
    if (append) begin
      wr_addr     = count_after[IDX_W-1:0];
      wr_data.key = cur.key;
      wr_data.blk = cur.block_num;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // Output beat: a new result loads once the old one has gone
      if ((state == S_DONE) && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
        res_data  <= result;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (op_valid) begin
            cur       <= op_data;
            rd_idx    <= '0;
            rd_pend   <= 1'b0;
            removed   <= 1'b0;
            found     <= 1'b0;
            best_key  <= '0;
            match_blk <= '0;
            top_key   <= '0;
            top_blk   <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= issue;
          rd_at   <= rd_idx[IDX_W-1:0];
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (hit) begin
            removed <= 1'b1;
          end
          if (top_upd) begin
            top_key <= rd_data.key;
            top_blk <= rd_data.blk;
          end
          if (srch_upd) begin
            found     <= 1'b1;
            best_key  <= rd_data.key;
            match_blk <= rd_data.blk;
          end
          if (!issue && !rd_pend) begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          result.match_block <= match_blk;
          result.found       <= found;
          result.status      <= (cur.cmd == CMD_ADD) && !room;
          if (append && (cur.key > top_key)) begin
            result.top_block <= cur.block_num;
          end else begin
            result.top_block <= top_blk;
          end
          if (append) begin
            count <= count_after + 1'b1;
          end else begin
            count <= count_after;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `include "block_index_table_defines.svh"

  `BIDX_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(ENTRIES))
  `BIDX_ASSERT_SAME(a_no_port_clash, rd_en && wr_en, rd_addr != wr_addr)
  `BIDX_ASSERT_NEXT(a_op_starts_scan, op_valid && !op_stall, state == S_SCAN)
  `BIDX_ASSERT_NEXT(a_count_step, 1'b1, (count - $past(count) + 1'b1) <= CNT_W'(2))

endmodule

// ----- tb/tb_block_index_table.sv -----
`timescale 1ns / 1ps
module tb_block_index_table;
  import bidx_pkg::*;

  // Spare command code: no table change, top block still reported
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int MAX_KEY   = 99999;
  localparam int MAX_BLK   = 65535;
  localparam int LIMIT     = 1000000;
  localparam int QUIET_LO  = 10000;
  localparam int QUIET_HI  = 30000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic op_valid = 1'b0;
  logic op_stall;
  op_t  op_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  block_index_table dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op_data   (op_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the table
  logic [KEY_W-1:0] tab_key [ENTRIES];
  logic [BLK_W-1:0] tab_blk [ENTRIES];
  int               tab_len;

  op_t  pending_ops [$];
  res_t expected_res [$];

  int cycle_count = 0;
  int errors      = 0;
  int checked     = 0;
  int adds_full   = 0;
  int search_hits = 0;
  int peak_len    = 0;

  // Remove the earliest row holding blk and close up the gap
  function automatic void drop_block(logic [BLK_W-1:0] blk);
    int i, j;
    for (i = 0; i < tab_len; i++) begin
      if (tab_blk[i] == blk) begin
        for (j = i; j + 1 < tab_len; j++) begin
          tab_key[j] = tab_key[j+1];
          tab_blk[j] = tab_blk[j+1];
        end
        tab_len--;
        return;
      end
    end
  endfunction

  // Apply one op to the local table and work out its result beat
  function automatic res_t table_op(op_t op);
    res_t             r;
    logic [KEY_W-1:0] best;
    logic [KEY_W-1:0] top_key;
    int               i;
    r = '0;
    case (op.cmd)
      CMD_ADD: begin
        drop_block(op.block_num);
        if (tab_len < ENTRIES) begin
          tab_key[tab_len] = op.key;
          tab_blk[tab_len] = op.block_num;
          tab_len++;
        end else begin
          r.status = 1'b1;
          adds_full++;
        end
      end
      CMD_DEL: drop_block(op.block_num);
      CMD_SEARCH: begin
        best = '0;
        for (i = 0; i < tab_len; i++) begin
          if (tab_key[i] >= op.key && (!r.found || tab_key[i] < best)) begin
            best          = tab_key[i];
            r.match_block = tab_blk[i];
            r.found       = 1'b1;
          end
        end
        if (r.found) search_hits++;
      end
      default: ;
    endcase
    // strict compare keeps the earliest row on a tie; key zero never qualifies
    top_key = '0;
    for (i = 0; i < tab_len; i++) begin
      if (tab_key[i] > top_key) begin
        top_key     = tab_key[i];
        r.top_block = tab_blk[i];
      end
    end
    if (tab_len > peak_len) peak_len = tab_len;
    return r;
  endfunction

  function automatic void check_field(string name, logic [BLK_W-1:0] exp_val,
                                      logic [BLK_W-1:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val, got_val);
      errors++;
    end
  endfunction

  // Random idling, switched off over one long window
  function automatic bit take_break();
    if (cycle_count >= QUIET_LO && cycle_count < QUIET_HI) return 1'b0;
    return $urandom_range(99) < 11;
  endfunction

  task automatic push_op(logic [1:0] cmd, int key, int blk);
    op_t op;
    op.cmd       = cmd;
    op.key       = key[KEY_W-1:0];
    op.block_num = blk[BLK_W-1:0];
    pending_ops = {pending_ops, op};
  endtask

  // Run the table up to full, then add when full: a new block is dropped,
  // a block already present is moved, a freed slot takes the next add
  task automatic fill_table(int base);
    int i;
    for (i = 0; i < ENTRIES + 6; i++)
      push_op(CMD_ADD, $urandom_range(MAX_KEY), base + i);
    push_op(CMD_ADD, $urandom_range(MAX_KEY), base + 10);
    push_op(CMD_SEARCH, $urandom_range(MAX_KEY), 0);
    push_op(CMD_DEL, 0, base + 3);
    push_op(CMD_ADD, $urandom_range(MAX_KEY), base + ENTRIES + 5);
    push_op(CMD_ADD, $urandom_range(MAX_KEY), base + ENTRIES + 4);
  endtask

  // Op driver: predict on each accepted beat, then offer the next
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      if (op_valid && !op_stall) expected_res = {expected_res, table_op(op_data)};
      if (!op_valid || !op_stall) begin
        if (pending_ops.size() > 0 && !take_break()) begin
          op_data  <= pending_ops.pop_front();
          op_valid <= 1'b1;
        end else begin
          op_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, res_data);
          errors++;
        end else begin
          res_t e;
          e = expected_res.pop_front();
          check_field("match_block", e.match_block, res_data.match_block);
          check_field("found", BLK_W'(e.found), BLK_W'(res_data.found));
          check_field("top_block", e.top_block, res_data.top_block);
          check_field("status", BLK_W'(e.status), BLK_W'(res_data.status));
          checked++;
        end
      end
      res_stall <= take_break();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_count == LIMIT) begin
      $display("timeout with %0d results outstanding", expected_res.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int seg, n, blk_span, key_span, add_pct, roll, cmd_pick;
    logic [1:0] cmd;

    // Empty table, spare code, key zero, extremes and ties
    push_op(CMD_SEARCH, 0, 0);
    push_op(CMD_DEL, 0, 5);
    push_op(CMD_SPARE, 0, 0);
    push_op(CMD_ADD, 0, MAX_BLK);
    push_op(CMD_SEARCH, 0, 0);
    push_op(CMD_ADD, MAX_KEY, 0);
    push_op(CMD_ADD, 500, 7);
    push_op(CMD_ADD, 500, 8);
    push_op(CMD_SEARCH, 500, 0);
    push_op(CMD_SEARCH, 1, 0);
    push_op(CMD_SEARCH, MAX_KEY, 0);
    push_op(CMD_ADD, 1000, 7);
    push_op(CMD_SEARCH, 501, 0);
    push_op(CMD_DEL, 0, 1234);
    push_op(CMD_DEL, 0, 8);
    push_op(CMD_SPARE, MAX_KEY, MAX_BLK);
    push_op(CMD_ADD, MAX_KEY, 9);
    push_op(CMD_SEARCH, MAX_KEY, 0);
    push_op(CMD_DEL, 0, 0);
    push_op(CMD_SEARCH, 99998, 0);
    push_op(CMD_DEL, 0, MAX_BLK);
    push_op(CMD_DEL, 0, 9);
    push_op(CMD_DEL, 0, 7);
    push_op(CMD_SEARCH, 0, 0);

    fill_table(1000);

    // Random segments: narrow or wide block and key ranges, varying add mix
    for (seg = 0; seg < 14; seg++) begin
      case ($urandom_range(2))
        0:       blk_span = 7;
        1:       blk_span = 79;
        default: blk_span = MAX_BLK;
      endcase
      key_span = ($urandom_range(1) == 0) ? 15 : MAX_KEY;
      add_pct  = $urandom_range(80, 30);
      if (seg == 7) fill_table($urandom_range(60000));
      for (n = 0; n < 100; n++) begin
        roll = $urandom_range(99);
        if (roll < add_pct)
          cmd = CMD_ADD;
        else if (roll >= 97)
          cmd = CMD_SPARE;
        else begin
          cmd_pick = $urandom_range(1);
          cmd = cmd_pick ? CMD_SEARCH : CMD_DEL;
        end
        push_op(cmd, $urandom_range(key_span), $urandom_range(blk_span));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || op_valid) @(posedge clk);
    while (expected_res.size() != 0) @(posedge clk);
    repeat (ENTRIES + 20) @(posedge clk);

    $display("checked %0d result beats; %0d searches hit, %0d adds dropped on a full table",
             checked, search_hits, adds_full);
    $display("table peaked at %0d of %0d rows", peak_len, ENTRIES);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
